// File: sv/assert_macros.svh
// Assertion macros shared by the ramped one-pole filter RTL.
// Included by every file that carries concurrent assertions; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define RPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpf assertion failed");

// Check that cons holds in the cycle after ante.
`define RPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpf assertion failed");

`endif

// File: sv/rpf_pkg.sv
// Shared types, codes and constants of the ramped one-pole filter.
// No dependencies; compiled before every other file of the block.
`timescale 1ns / 1ps

package rpf_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int COEFF_BITS       = 16;
    localparam int CH_BITS          = 3;
    localparam int CNT_BITS         = 4;
    localparam int CFG_IDX_BITS     = 1;
    localparam int CFG_DATA_BITS    = 4;
    localparam int DEF_MAX_CHANNELS = 8;
    localparam int QUEUE_DEPTH      = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_FILTER_MODE  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_CHANNELS = 1'b1;

    typedef enum logic {
        OP_SAMPLE   = 1'b0,
        OP_RETARGET = 1'b1
    } op_t;

    typedef enum logic {
        MODE_LOWPASS  = 1'b0,
        MODE_HIGHPASS = 1'b1
    } mode_t;

    // Classified word handed from the front to the back through the queue
    typedef struct packed {
        op_t                            op;
        logic                           in_use;
        logic                           frame_start;
        logic [CH_BITS-1:0]             channel;
        logic signed [SAMPLE_BITS-1:0]  sample;
        logic [COEFF_BITS-1:0]          target;
        logic [COEFF_BITS-1:0]          ramp;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
    } cfg_t;

    // Number of delay entries that a channel index can reach
    function automatic int store_depth(input int max_ch);
        int lim;
        lim = 1 << CH_BITS;
        return (max_ch < lim) ? max_ch : lim;
    endfunction

endpackage

// File: sv/rpf_ifs.sv
// Valid/ready channel interfaces of the ramped one-pole filter.
// Depends on rpf_pkg for field widths.
`timescale 1ns / 1ps

interface rpf_in_if;
    import rpf_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [CH_BITS-1:0]            channel;
    logic                          frame_start;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [COEFF_BITS-1:0]         target_coeff;
    logic [COEFF_BITS-1:0]         ramp_frames;

    modport source (
        output valid, opcode, channel, frame_start, sample_in, target_coeff, ramp_frames,
        input  ready
    );
    modport sink (
        input  valid, opcode, channel, frame_start, sample_in, target_coeff, ramp_frames,
        output ready
    );
endinterface

interface rpf_out_if;
    import rpf_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [CH_BITS-1:0]            out_channel;

    modport source (output valid, sample_out, out_channel, input ready);
    modport sink (input valid, sample_out, out_channel, output ready);
endinterface

// File: sv/ramped_one_pole_filter_unit.sv
// Top level of the ramped one-pole filter: front end, command queue, back end.
// Depends on rpf_pkg, rpf_ifs, rpf_front, rpf_queue and rpf_back.
//
// Usage:
//   item   - input words (valid/ready). opcode 0 carries one channel's sample,
//            opcode 1 retargets the coefficient ramp (target and length in frames).
//   result - one filtered, saturated sample per in-use sample word (valid/ready).
//   cfg_*  - register writes (filter mode, channel count); write only while idle.
// Flow:
//   A sample word passes the back end in its coefficient step, multiply and
//   round/saturate steps; its result is registered once the result register is free.
//   A retarget with a nonzero ramp length waits for its per-frame step, which
//   comes from a restoring divider that resolves one quotient bit a cycle.
//   Other retargets and words for channels not in use finish in the idle state.
//   A two-entry queue keeps accepting words while the back end is busy.
// Reset clears the coefficient ramp, the delay store and all handshake state.
// While the receiver stalls, the finished result is held and the back end
// waits with its next result; input words keep flowing until the queue fills.
`timescale 1ns / 1ps

module ramped_one_pole_filter_unit #(
    parameter int MAX_CHANNELS = rpf_pkg::DEF_MAX_CHANNELS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    rpf_in_if.sink                             item,
    rpf_out_if.source                          result,
    input  logic                               cfg_we,
    input  logic [rpf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [rpf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import rpf_pkg::*;

    logic push;
    cmd_t push_data;
    logic full;
    logic pop;
    cmd_t pop_data;
    logic empty;
    cfg_t cfg;

    rpf_front #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .cfg       (cfg)
    );

    rpf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    rpf_back #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .has_cmd (!empty),
        .cmd     (pop_data),
        .take    (pop),
        .cfg     (cfg),
        .result  (result)
    );

endmodule

// File: sv/rpf_front.sv
// Front end: configuration registers, input word acceptance and classification.
// Depends on rpf_pkg and rpf_ifs.
`timescale 1ns / 1ps

module rpf_front #(
    parameter int MAX_CHANNELS = rpf_pkg::DEF_MAX_CHANNELS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    rpf_in_if.sink                             item,
    input  logic                               cfg_we,
    input  logic [rpf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [rpf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output logic                               push,
    output rpf_pkg::cmd_t                      push_data,
    input  logic                               full,
    output rpf_pkg::cfg_t                      cfg
);
    import rpf_pkg::*;

    localparam logic [CNT_BITS-1:0] CH_LIMIT = CNT_BITS'(store_depth(MAX_CHANNELS));

    mode_t               mode_reg;
    logic [CNT_BITS-1:0] chan_cnt_reg;
    logic [CNT_BITS-1:0] ch_wide;
    logic                in_use;

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_LOWPASS;
            chan_cnt_reg <= CNT_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FILTER_MODE:  mode_reg     <= mode_t'(cfg_data[0]);
                REG_NUM_CHANNELS: chan_cnt_reg <= cfg_data[CNT_BITS-1:0];
                default:          mode_reg     <= mode_reg;
            endcase
        end
    end

    // Channel in use: below the count (zero acts as one) and below the store depth
    always_comb
    begin
        ch_wide = CNT_BITS'(item.channel);
        in_use  = ((ch_wide < chan_cnt_reg) || (ch_wide == '0)) && (ch_wide < CH_LIMIT);
    end

    // Accept whenever the queue has room, and classify the word on the way in
    assign item.ready = !full;
    assign push       = item.valid && !full;

    always_comb
    begin
        push_data.op          = op_t'(item.opcode);
        push_data.in_use      = in_use;
        push_data.frame_start = item.frame_start;
        push_data.channel     = item.channel;
        push_data.sample      = item.sample_in;
        push_data.target      = item.target_coeff;
        push_data.ramp        = item.ramp_frames;
    end

    assign cfg.mode = mode_reg;

endmodule

// File: sv/rpf_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on rpf_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rpf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rpf_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output rpf_pkg::cmd_t pop_data,
    output logic          empty
);
    import rpf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    `RPF_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !full)
    `RPF_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, !empty)
    `RPF_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(QUEUE_DEPTH))

endmodule

// File: sv/rpf_back.sv
// Back end: coefficient ramp, step divider, per-channel filter and result register.
// Depends on rpf_pkg and rpf_ifs.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rpf_back #(
    parameter int MAX_CHANNELS = rpf_pkg::DEF_MAX_CHANNELS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          has_cmd,
    input  rpf_pkg::cmd_t cmd,
    output logic          take,
    input  rpf_pkg::cfg_t cfg,
    rpf_out_if.source     result
);
    import rpf_pkg::*;

    localparam int STORE_DEPTH = store_depth(MAX_CHANNELS);
    localparam int IDX_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int Z_BITS = SAMPLE_BITS + 2;
    localparam int D_BITS = Z_BITS + 1;
    localparam int P_BITS = D_BITS + COEFF_BITS + 1;
    localparam int R_BITS = P_BITS - COEFF_BITS;
    localparam int A_BITS = R_BITS + 2;
    localparam int Q_BITS = 2 * COEFF_BITS;
    localparam int DC_W   = $clog2(Q_BITS);
    localparam logic signed [P_BITS-1:0] HALF = P_BITS'(1) << (COEFF_BITS - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_DIV  = 4'b1000
    } state_t;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [A_BITS-1:0] v
    );
        logic signed [A_BITS-1:0] hi;
        logic signed [A_BITS-1:0] lo;
        hi = {{(A_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            return hi[SAMPLE_BITS-1:0];
        else if (v < lo)
            return lo[SAMPLE_BITS-1:0];
        else
            return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic signed [Z_BITS-1:0] sat_delay(
        input logic signed [A_BITS-1:0] v
    );
        logic signed [A_BITS-1:0] hi;
        logic signed [A_BITS-1:0] lo;
        hi = {{(A_BITS-Z_BITS+1){1'b0}}, {(Z_BITS-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            return hi[Z_BITS-1:0];
        else if (v < lo)
            return lo[Z_BITS-1:0];
        else
            return v[Z_BITS-1:0];
    endfunction

    state_t                         state_reg, state_next;
    logic [Q_BITS-1:0]              coeff_now_reg, coeff_now_next;
    logic [Q_BITS-1:0]              coeff_step_reg, coeff_step_next;
    logic [COEFF_BITS-1:0]          coeff_goal_reg, coeff_goal_next;
    logic [COEFF_BITS-1:0]          ramp_count_reg, ramp_count_next;
    logic [COEFF_BITS-1:0]          ramp_len_reg, ramp_len_next;
    logic [DC_W-1:0]                div_cnt_reg, div_cnt_next;
    logic                           div_neg_reg, div_neg_next;
    logic [COEFF_BITS-1:0]          rem_reg, rem_next;
    logic [Q_BITS-1:0]              quo_reg, quo_next;
    logic signed [SAMPLE_BITS-1:0]  x_reg, x_next;
    logic signed [Z_BITS-1:0]       z_reg, z_next;
    logic [CH_BITS-1:0]             ch_reg, ch_next;
    logic signed [P_BITS-1:0]       prod_reg, prod_next;
    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0]  out_sample_reg;
    logic [CH_BITS-1:0]             out_ch_reg;
    logic signed [Z_BITS-1:0]       delay_reg [STORE_DEPTH];

    logic                           out_load;
    logic                           store_we;
    logic [COEFF_BITS:0]            rem_sh;
    logic                           rem_ge;
    logic [COEFF_BITS:0]            rem_sub;
    logic [Q_BITS-1:0]              goal_full;
    logic signed [Q_BITS:0]         diff;
    logic [Q_BITS-1:0]              mag;
    logic [COEFF_BITS-1:0]          count_inc;
    logic signed [Z_BITS-1:0]       z_rd;
    logic signed [D_BITS-1:0]       d_val;
    logic signed [COEFF_BITS:0]     b_val;
    logic signed [P_BITS-1:0]       t_val;
    logic signed [R_BITS-1:0]       rnd;
    logic signed [A_BITS-1:0]       x_a, z_a, r_a;
    logic signed [A_BITS-1:0]       lp_sum, hp_lp, hp_z, hp_y;
    logic signed [SAMPLE_BITS-1:0]  y_val;
    logic signed [Z_BITS-1:0]       z_new;

    // Divider step: one quotient bit per cycle
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[Q_BITS-1]};
        rem_sub = rem_sh - {1'b0, ramp_len_reg};
        rem_ge  = (rem_sh >= {1'b0, ramp_len_reg});
    end

    // Distance from the current coefficient to a new goal
    always_comb
    begin
        goal_full = {cmd.target, {COEFF_BITS{1'b0}}};
        diff      = signed'({1'b0, goal_full}) - signed'({1'b0, coeff_now_reg});
        mag       = diff[Q_BITS] ? Q_BITS'(-diff) : diff[Q_BITS-1:0];
        count_inc = ramp_count_reg + 1'b1;
    end

    // Filter datapath: difference times coefficient, then round and saturate
    always_comb
    begin
        z_rd  = delay_reg[ch_reg[IDX_W-1:0]];
        b_val = signed'({1'b0, coeff_now_reg[Q_BITS-1:COEFF_BITS]});
        if (cfg.mode == MODE_LOWPASS)
            d_val = D_BITS'(z_rd) - D_BITS'(x_reg);
        else
            d_val = D_BITS'(x_reg) - D_BITS'(z_rd);
        t_val  = prod_reg + HALF;
        rnd    = t_val[P_BITS-1:COEFF_BITS];
        x_a    = A_BITS'(x_reg);
        z_a    = A_BITS'(z_reg);
        r_a    = A_BITS'(rnd);
        lp_sum = x_a + r_a;
        hp_lp  = r_a + z_a;
        hp_z   = r_a + hp_lp;
        hp_y   = x_a - hp_lp;
        if (cfg.mode == MODE_LOWPASS)
        begin
            y_val = sat_sample(lp_sum);
            z_new = Z_BITS'(y_val);
        end
        else
        begin
            y_val = sat_sample(hp_y);
            z_new = sat_delay(hp_z);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        coeff_now_next  = coeff_now_reg;
        coeff_step_next = coeff_step_reg;
        coeff_goal_next = coeff_goal_reg;
        ramp_count_next = ramp_count_reg;
        ramp_len_next   = ramp_len_reg;
        div_cnt_next    = div_cnt_reg;
        div_neg_next    = div_neg_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        x_next          = x_reg;
        z_next          = z_reg;
        ch_next         = ch_reg;
        prod_next       = prod_reg;
        take            = 1'b0;
        out_load        = 1'b0;
        store_we        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (has_cmd)
                begin
                    take = 1'b1;
                    case (cmd.op)
                        OP_RETARGET:
                        begin
                            // A repeated goal leaves the ramp alone
                            if (cmd.target != coeff_goal_reg)
                            begin
                                coeff_goal_next = cmd.target;
                                ramp_count_next = '0;
                                if (cmd.ramp == '0)
                                begin
                                    coeff_now_next  = goal_full;
                                    coeff_step_next = '0;
                                    ramp_len_next   = '0;
                                end
                                else
                                begin
                                    ramp_len_next = cmd.ramp;
                                    div_neg_next  = diff[Q_BITS];
                                    quo_next      = mag;
                                    rem_next      = '0;
                                    div_cnt_next  = '0;
                                    state_next    = ST_DIV;
                                end
                            end
                        end
                        OP_SAMPLE:
                        begin
                            // Step the coefficient at a frame start; land exactly on the goal
                            if (cmd.frame_start && (ramp_count_reg < ramp_len_reg))
                            begin
                                ramp_count_next = count_inc;
                                if (count_inc == ramp_len_reg)
                                    coeff_now_next = {coeff_goal_reg, {COEFF_BITS{1'b0}}};
                                else
                                    coeff_now_next = coeff_now_reg + coeff_step_reg;
                            end
                            if (cmd.in_use)
                            begin
                                x_next     = cmd.sample;
                                ch_next    = cmd.channel;
                                state_next = ST_MUL;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                z_next     = z_rd;
                prod_next  = d_val * b_val;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // Hold until the result register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    store_we   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                rem_next     = rem_ge ? rem_sub[COEFF_BITS-1:0] : rem_sh[COEFF_BITS-1:0];
                quo_next     = {quo_reg[Q_BITS-2:0], rem_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DC_W'(Q_BITS - 1))
                begin
                    coeff_step_next = div_neg_reg ? (~quo_next + 1'b1) : quo_next;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            coeff_now_reg  <= '0;
            coeff_step_reg <= '0;
            coeff_goal_reg <= '0;
            ramp_count_reg <= '0;
            ramp_len_reg   <= '0;
            div_cnt_reg    <= '0;
            div_neg_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            coeff_now_reg  <= coeff_now_next;
            coeff_step_reg <= coeff_step_next;
            coeff_goal_reg <= coeff_goal_next;
            ramp_count_reg <= ramp_count_next;
            ramp_len_reg   <= ramp_len_next;
            div_cnt_reg    <= div_cnt_next;
            div_neg_reg    <= div_neg_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Working registers of the current word
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        x_reg    <= x_next;
        z_reg    <= z_next;
        ch_reg   <= ch_next;
        prod_reg <= prod_next;
        if (out_load)
        begin
            out_sample_reg <= y_val;
            out_ch_reg     <= ch_reg;
        end
    end

    // Per-channel delay store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
                delay_reg[i] <= '0;
        end
        else if (store_we)
        begin
            delay_reg[ch_reg[IDX_W-1:0]] <= z_new;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.sample_out  = out_sample_reg;
    assign result.out_channel = out_ch_reg;

    `RPF_ASSERT_NOW(a_ramp_bound, clk, rst_n, 1'b1, ramp_count_reg <= ramp_len_reg)
    `RPF_ASSERT_NOW(a_load_in_fin, clk, rst_n, out_load, state_reg == ST_FIN)
    `RPF_ASSERT_NOW(a_no_take_busy, clk, rst_n, state_reg != ST_IDLE, !take)
    `RPF_ASSERT_NEXT(a_fin_follows_mul, clk, rst_n, state_reg == ST_MUL, state_reg == ST_FIN)

endmodule
